### sv/asi_pkg.sv
// shared types, constants and codes of the address interval set
package asi_pkg;

   // default sizes of the store
   localparam int DEF_MAX_INTERVALS = 16;
   localparam int DEF_TAG_BITS      = 16;

   // fixed field widths of the streams
   localparam int ADDR_BITS   = 64;
   localparam int TAG_IN_BITS = 16;
   localparam int COUNT_BITS  = 5;
   localparam int STATUS_BITS = 2;

   // packed stream widths, whole bytes
   localparam int REQ_BITS = 208;
   localparam int RSP_BITS = 160;

   // request kinds carried in req_tuser
   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic scan;
      logic advance;
      logic insert;
      logic tail;
      logic reply;
   } asi_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_query;
      logic bad_range;
      logic set_empty;
      logic last_entry;
      logic hit;
      logic need_ins;
      logic out_free;
   } asi_stat_type;

endpackage

### sv/asi_ram.sv
// generic simple dual port ram with registered read
module asi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### sv/asi_ctrl.sv
// sequencer that walks the interval store for one request at a time
module asi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  asi_pkg::asi_stat_type stat,
   output asi_pkg::asi_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_INSERT,
      ST_TAIL,
      ST_REPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            if (!stat.is_query && stat.bad_range) begin
               state_in = ST_REPLY;
            end else if (stat.set_empty) begin
               state_in = stat.is_query ? ST_REPLY : ST_TAIL;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = ST_REPLY;
            end else if (stat.need_ins) begin
               state_in = ST_INSERT;
            end else if (stat.last_entry) begin
               state_in = stat.is_query ? ST_REPLY : ST_TAIL;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            if (stat.last_entry) begin
               state_in = ST_TAIL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_TAIL: begin
            cmd.tail = 1'b1;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (stat.out_free) begin
               cmd.reply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/asi_dpath.sv
// datapath: request registers, merge logic, double banked store and result register
module asi_dpath #(
   parameter int MAX_INTERVALS = asi_pkg::DEF_MAX_INTERVALS,
   parameter int TAG_BITS      = asi_pkg::DEF_TAG_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  asi_pkg::asi_cmd_type          cmd,
   output asi_pkg::asi_stat_type         stat,
   input  logic [asi_pkg::REQ_BITS-1:0]  req_tdata,
   input  logic [0:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [asi_pkg::RSP_BITS-1:0]  rsp_tdata
);

   localparam int AB = asi_pkg::ADDR_BITS;
   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int KW = $clog2(MAX_INTERVALS + 1);
   localparam int EW = 2 * AB + TAG_BITS;
   localparam int RAM_DEPTH = 2 ** (IW + 1);

   // request registers
   logic                 query_ff;
   logic [AB-1:0]        start_ff;
   logic [AB-1:0]        end_ff;
   logic [TAG_BITS-1:0]  tag_ff;
   logic [AB-1:0]        probe_ff;

   // scan state
   logic [AB-1:0] ms_ff, ms_in;
   logic [AB-1:0] me_ff, me_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] used_ff, used_in;
   logic          bank_ff, bank_in;
   logic          placed_ff, placed_in;
   logic          full_ff, full_in;
   logic          hit_ff, hit_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [asi_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   // store access
   logic [EW-1:0]       rd_data;
   logic [EW-1:0]       wr_data;
   logic [IW:0]         rd_addr;
   logic [IW:0]         wr_addr;
   logic                wr_en;
   logic                wr_req;
   logic                wr_merged;
   logic [AB-1:0]       ent_start;
   logic [AB-1:0]       ent_end;
   logic [TAG_BITS-1:0] ent_tag;

   // per entry decisions
   logic overlap;
   logic covers;
   logic probe_hit;
   logic hit_now;
   logic need_ins;
   logic last_entry;
   logic k_at_cap;
   logic commit;
   logic found;
   asi_pkg::status_type status;

   assign ent_start = rd_data[AB-1:0];
   assign ent_end   = rd_data[2*AB-1:AB];
   assign ent_tag   = rd_data[2*AB +: TAG_BITS];

   // interval compares against the entry on the read port
   assign overlap    = (ent_start <= end_ff) && (ent_end >= start_ff);
   assign covers     = (ent_start <= start_ff) && (end_ff <= ent_end);
   assign probe_hit  = (ent_start <= probe_ff) && (probe_ff < ent_end);
   assign hit_now    = query_ff ? probe_hit : covers;
   assign need_ins   = !query_ff && !overlap && !placed_ff && (ms_ff < ent_start);
   assign last_entry = (KW'(idx_ff) + KW'(1)) == used_ff;
   assign k_at_cap   = k_ff == KW'(MAX_INTERVALS);

   // status toward the controller
   assign stat.is_query   = query_ff;
   assign stat.bad_range  = start_ff >= end_ff;
   assign stat.set_empty  = used_ff == '0;
   assign stat.last_entry = last_entry;
   assign stat.hit        = hit_now;
   assign stat.need_ins   = need_ins;
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // compaction writes into the spare bank
   always_comb begin
      wr_req    = 1'b0;
      wr_merged = 1'b0;
      if (cmd.scan && !query_ff && !hit_now && !overlap) begin
         wr_req    = 1'b1;
         wr_merged = need_ins;
      end else if (cmd.insert) begin
         wr_req = 1'b1;
      end else if (cmd.tail && !placed_ff) begin
         wr_req    = 1'b1;
         wr_merged = 1'b1;
      end
   end

   assign wr_en   = wr_req && !k_at_cap;
   assign wr_addr = {~bank_ff, k_ff[IW-1:0]};
   assign wr_data = wr_merged ? {tag_ff, me_ff, ms_ff} : rd_data;

   // commit decision and result fields
   assign commit = !query_ff && !stat.bad_range && !hit_ff && !full_ff;
   assign found  = query_ff && hit_ff;

   always_comb begin
      if (query_ff) begin
         status = asi_pkg::STATUS_OK;
      end else if (stat.bad_range) begin
         status = asi_pkg::STATUS_RANGE;
      end else if (!hit_ff && full_ff) begin
         status = asi_pkg::STATUS_FULL;
      end else begin
         status = asi_pkg::STATUS_OK;
      end
   end

   // next values of the scan state
   always_comb begin
      ms_in     = ms_ff;
      me_in     = me_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      used_in   = used_ff;
      bank_in   = bank_ff;
      placed_in = placed_ff;
      full_in   = full_ff;
      hit_in    = hit_ff;
      if (cmd.capture) begin
         ms_in     = req_tdata[AB-1:0];
         me_in     = req_tdata[2*AB-1:AB];
         idx_in    = '0;
         k_in      = '0;
         placed_in = 1'b0;
         full_in   = 1'b0;
         hit_in    = 1'b0;
      end else begin
         // widen the merged interval over each overlapping entry
         if (cmd.scan && !query_ff && overlap && !covers) begin
            if (ent_start < ms_ff) begin
               ms_in = ent_start;
            end
            if (ent_end > me_ff) begin
               me_in = ent_end;
            end
         end
         if (cmd.scan && hit_now) begin
            hit_in = 1'b1;
         end
         if (wr_req && wr_merged) begin
            placed_in = 1'b1;
         end
         if (wr_req && k_at_cap) begin
            full_in = 1'b1;
         end
         if (wr_en) begin
            k_in = k_ff + KW'(1);
         end
         if (cmd.advance) begin
            idx_in = idx_ff + IW'(1);
         end
         if (cmd.reply && commit) begin
            bank_in = ~bank_ff;
            used_in = k_ff;
         end
      end
   end

   // next result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[0]       = commit;
         rsp_data_in[1]       = found;
         rsp_data_in[65:2]    = found ? ent_start : '0;
         rsp_data_in[129:66]  = found ? ent_end : '0;
         rsp_data_in[145:130] = found ? asi_pkg::TAG_IN_BITS'(ent_tag) : '0;
         rsp_data_in[147:146] = status;
         rsp_data_in[152:148] = asi_pkg::COUNT_BITS'(commit ? k_ff : used_ff);
      end
   end

   // read the entry that the next cycle works on
   assign rd_addr = {bank_in, idx_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         k_ff         <= '0;
         used_ff      <= '0;
         bank_ff      <= 1'b0;
         placed_ff    <= 1'b0;
         full_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         used_ff      <= used_in;
         bank_ff      <= bank_in;
         placed_ff    <= placed_in;
         full_ff      <= full_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= req_tuser[0] != asi_pkg::CMD_ADD;
         start_ff <= req_tdata[AB-1:0];
         end_ff   <= req_tdata[2*AB-1:AB];
         tag_ff   <= TAG_BITS'(req_tdata[2*AB +: asi_pkg::TAG_IN_BITS]);
         probe_ff <= req_tdata[2*AB+asi_pkg::TAG_IN_BITS +: AB];
      end
      ms_ff       <= ms_in;
      me_ff       <= me_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // two banks: one holds the live set, the other takes the compacted copy
   asi_ram #(
      .WIDTH (EW),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### sv/address_interval_set.sv
// top level of the address interval set
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tuser: kind; tdata: start, end, tag, probe
//   rsp_     out  rsp_tvalid/tready     tdata: flags, found interval, status, count
//
// a merging add walks all N stored intervals before its result is loaded, with an extra
// insert step when the merged interval lands ahead of a kept one; a reversed or empty add
// skips the scan; a query or an already covered add stops at the first matching interval
// outside the insert step the scan reads one stored interval per cycle via the read port
// reset empties the set at once by clearing the interval count, no clearing pass
// a finished result waits in the output register while the next request is taken;
// the block stalls before loading a new result until the previous one is transferred
module address_interval_set #(
   parameter int MAX_INTERVALS = asi_pkg::DEF_MAX_INTERVALS,
   parameter int TAG_BITS      = asi_pkg::DEF_TAG_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // start_addr[63:0], end_addr[127:64], tag_in[143:128], probe_addr[207:144]
   input  logic [asi_pkg::REQ_BITS-1:0] req_tdata,
   // command[0]
   input  logic [0:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // changed[0], found[1], found_start[65:2], found_end[129:66],
   // found_tag[145:130], status[147:146], interval_count[152:148], zero fill
   output logic [asi_pkg::RSP_BITS-1:0] rsp_tdata
);

   asi_pkg::asi_cmd_type  cmd;
   asi_pkg::asi_stat_type stat;

   // sequencer
   asi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath and store
   asi_dpath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .TAG_BITS      (TAG_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // at most one of capture, scan, insert, tail and reply per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.scan, cmd.insert, cmd.tail, cmd.reply}))
      else $error("overlapping datapath commands");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten");

   // the scan never steps past the last stored interval
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> !stat.last_entry)
      else $error("scan ran past the set");

   // a new request is taken only when the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("request taken during a scan");

endmodule

### tb/address_interval_set_checker.sv
// checker of the address interval set: predicts each result and compares transfers
module address_interval_set_checker #(
   parameter int MAX_SPANS = asi_pkg::DEF_MAX_INTERVALS,
   parameter int TAG_BITS  = asi_pkg::DEF_TAG_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   // start_addr[63:0], end_addr[127:64], tag_in[143:128], probe_addr[207:144]
   input  logic [asi_pkg::REQ_BITS-1:0] req_tdata,
   // command[0]
   input  logic [0:0]                   req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // changed[0], found[1], found_start[65:2], found_end[129:66],
   // found_tag[145:130], status[147:146], interval_count[152:148], zero fill
   input  logic [asi_pkg::RSP_BITS-1:0] rsp_tdata,
   output int                           fail_count,
   output int                           replies_waiting
);

   localparam logic [15:0] TAG_KEEP =
      (TAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TAG_BITS) - 1);

   typedef struct packed {
      logic                changed;
      logic                found;
      logic [63:0]         lo;
      logic [63:0]         hi;
      logic [15:0]         tag;
      asi_pkg::status_type status;
      logic [4:0]          count;
   } outcome_type;

   // own copy of the sorted interval store
   logic [63:0] span_lo  [MAX_SPANS];
   logic [63:0] span_hi  [MAX_SPANS];
   logic [15:0] span_tag [MAX_SPANS];
   int          span_count;

   outcome_type outcomes_due [$];
   outcome_type seen;
   outcome_type due;
   int          reports;

   // apply one request to the store copy and return its result
   function automatic outcome_type apply_request(asi_pkg::command_type cmd,
                                                 logic [63:0] s, logic [63:0] e,
                                                 logic [15:0] t, logic [63:0] p);
      outcome_type r;
      logic [63:0] ms;
      logic [63:0] me;
      logic [63:0] new_lo  [MAX_SPANS];
      logic [63:0] new_hi  [MAX_SPANS];
      logic [15:0] new_tag [MAX_SPANS];
      int          kept;
      int          k;
      bit          placed;
      bit          covered;
      r = '0;
      r.status = asi_pkg::STATUS_OK;
      if (cmd == asi_pkg::CMD_ADD) begin
         if (s >= e) begin
            r.status = asi_pkg::STATUS_RANGE;
         end else begin
            covered = 0;
            for (int i = 0; i < span_count; i++)
               if (span_lo[i] <= s && e <= span_hi[i]) covered = 1;
            if (!covered) begin
               // closed comparisons: touching intervals merge too
               ms = s;
               me = e;
               kept = 0;
               for (int i = 0; i < span_count; i++) begin
                  if (span_lo[i] <= e && span_hi[i] >= s) begin
                     if (span_lo[i] < ms) ms = span_lo[i];
                     if (span_hi[i] > me) me = span_hi[i];
                  end else begin
                     kept++;
                  end
               end
               if (kept + 1 > MAX_SPANS) begin
                  r.status = asi_pkg::STATUS_FULL;
               end else begin
                  // rebuild in start order with the merged interval in place
                  k = 0;
                  placed = 0;
                  for (int i = 0; i < span_count; i++) begin
                     if (!(span_lo[i] <= e && span_hi[i] >= s)) begin
                        if (!placed && ms < span_lo[i]) begin
                           new_lo[k] = ms;
                           new_hi[k] = me;
                           new_tag[k] = t & TAG_KEEP;
                           k++;
                           placed = 1;
                        end
                        new_lo[k] = span_lo[i];
                        new_hi[k] = span_hi[i];
                        new_tag[k] = span_tag[i];
                        k++;
                     end
                  end
                  if (!placed) begin
                     new_lo[k] = ms;
                     new_hi[k] = me;
                     new_tag[k] = t & TAG_KEEP;
                     k++;
                  end
                  for (int i = 0; i < k; i++) begin
                     span_lo[i] = new_lo[i];
                     span_hi[i] = new_hi[i];
                     span_tag[i] = new_tag[i];
                  end
                  span_count = k;
                  r.changed = 1'b1;
               end
            end
         end
      end else begin
         // first interval holding the probe, end exclusive
         for (int i = 0; i < span_count; i++) begin
            if (!r.found && span_lo[i] <= p && p < span_hi[i]) begin
               r.found = 1'b1;
               r.lo = span_lo[i];
               r.hi = span_hi[i];
               r.tag = span_tag[i];
            end
         end
      end
      r.count = span_count[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         span_count = 0;
         outcomes_due.delete();
         fail_count = 0;
         replies_waiting = 0;
         reports = 0;
      end else begin
         // result transfer against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen.changed = rsp_tdata[0];
            seen.found = rsp_tdata[1];
            seen.lo = rsp_tdata[65:2];
            seen.hi = rsp_tdata[129:66];
            seen.tag = rsp_tdata[145:130];
            seen.status = asi_pkg::status_type'(rsp_tdata[147:146]);
            seen.count = rsp_tdata[152:148];
            if (outcomes_due.size() == 0) begin
               fail_count++;
               if (reports < 10) begin
                  reports++;
                  $display("unexpected result transfer: %h", rsp_tdata);
               end
            end else begin
               due = outcomes_due.pop_front();
               if (seen !== due) begin
                  fail_count++;
                  if (reports < 10) begin
                     reports++;
                     $display("mismatch expected: chg=%0d fnd=%0d start=%h end=%h",
                              due.changed, due.found, due.lo, due.hi);
                     $display("                   tag=%h st=%0d n=%0d",
                              due.tag, due.status, due.count);
                     $display("mismatch actual:   chg=%0d fnd=%0d start=%h end=%h",
                              seen.changed, seen.found, seen.lo, seen.hi);
                     $display("                   tag=%h st=%0d n=%0d",
                              seen.tag, seen.status, seen.count);
                  end
               end
            end
         end
         // request transfer: predict its result
         if (req_tvalid && req_tready)
            outcomes_due.push_back(apply_request(asi_pkg::command_type'(req_tuser[0]),
                                                 req_tdata[63:0], req_tdata[127:64],
                                                 req_tdata[143:128], req_tdata[207:144]));
         replies_waiting = outcomes_due.size();
      end
   end

endmodule

### tb/address_interval_set_test.sv
// test top of the address interval set: stimulus, idling, watchdog and verdict
module address_interval_set_test;

   localparam logic [63:0] ADDR_TOP = '1;
   localparam int ITEM_TARGET    = 1040;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [asi_pkg::REQ_BITS-1:0] req_tdata;
   logic [0:0]                   req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [asi_pkg::RSP_BITS-1:0] rsp_tdata;
   int                           fail_count;
   int                           replies_waiting;

   bit                           steady;
   int                           sent_count;
   logic [63:0]                  marks [$];

   address_interval_set dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   address_interval_set_checker interval_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .replies_waiting (replies_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] any_addr();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_tag();
      case ($urandom_range(7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // one request transfer, with random idle cycles ahead of it outside the steady stretch
   task automatic send_request(input asi_pkg::command_type cmd, input logic [63:0] s,
                               input logic [63:0] e, input logic [15:0] t,
                               input logic [63:0] p);
      bit taken;
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= {p, t, e, s};
      req_tvalid <= 1'b1;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
         @(negedge clock);
      end
      sent_count++;
   endtask

   // add request; its bounds are kept for later probes
   task automatic add_span(input logic [63:0] s, input logic [63:0] e, input logic [15:0] t);
      send_request(asi_pkg::CMD_ADD, s, e, t, any_addr());
      marks.push_back(s);
      marks.push_back(e);
      while (marks.size() > 32) void'(marks.pop_front());
   endtask

   task automatic probe(input logic [63:0] p);
      send_request(asi_pkg::CMD_QUERY, any_addr(), any_addr(), pick_tag(), p);
   endtask

   // result side: random stalls except in the steady stretch
   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= 29);
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("address_interval_set_test failed");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] base;
      logic [63:0] s;
      logic [63:0] e;
      logic [63:0] m;
      int          window;
      int          pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = asi_pkg::CMD_ADD;
      steady = 0;
      sent_count = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, touching merges, inclusion, bad ranges
      probe(ADDR_TOP);
      add_span(64'd10, 64'd20, 16'hFFFF);
      add_span(64'd20, 64'd30, 16'h0000);
      add_span(64'd0, 64'd10, 16'h1234);
      add_span(64'd12, 64'd15, 16'h5555);
      add_span(64'd7, 64'd7, 16'h0001);
      add_span(ADDR_TOP, 64'd0, 16'h0002);
      probe(64'd0);
      probe(64'd30);
      // fill the table, overflow it, merge within it, then cover everything
      for (int i = 1; i <= 15; i++)
         add_span(64'(100 * i), 64'(100 * i + 50), 16'(i));
      add_span(64'd5000, 64'd5010, 16'h00AA);
      add_span(64'd150, 64'd200, 16'h00BB);
      add_span(64'd0, ADDR_TOP, 16'hA5A5);
      probe(ADDR_TOP - 64'd1);
      probe(ADDR_TOP);

      // random rounds of work within an address window
      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(9);
         if (pick < 2)
            base = '0;
         else if (pick == 2)
            base = ADDR_TOP - 64'd600;
         else
            base = any_addr();
         window = ($urandom_range(3) == 0) ? 4000 : 400;
         for (int n = 0; n < 24; n++) begin
            steady = (sent_count >= 330 && sent_count < 480);
            pick = $urandom_range(99);
            if (pick < 50) begin
               s = base + 64'($urandom_range(window));
               add_span(s, s + 64'($urandom_range(24, 1)), pick_tag());
            end else if (pick < 75 && marks.size() > 0) begin
               m = marks[$urandom_range(marks.size() - 1)];
               probe(m + 64'($urandom_range(2)) - 64'd1);
            end else if (pick < 85) begin
               probe(base + 64'($urandom_range(window)));
            end else if (pick < 90 && marks.size() > 0) begin
               // bridge between two known bounds, merging what lies between
               s = marks[$urandom_range(marks.size() - 1)];
               e = marks[$urandom_range(marks.size() - 1)];
               if (s > e) add_span(e, s, pick_tag());
               else add_span(s, e, pick_tag());
            end else if (pick < 95) begin
               add_span(any_addr(), any_addr(), pick_tag());
            end else begin
               s = base + 64'($urandom_range(window));
               add_span(s, s - 64'($urandom_range(3)), pick_tag());
            end
         end
         if ($urandom_range(3) == 0)
            add_span(base, base + 64'(window + 30), pick_tag());
         if ($urandom_range(7) == 0)
            add_span(64'd0, ADDR_TOP, pick_tag());
      end
      steady = 0;
      req_tvalid <= 1'b0;

      // drain, then let the pipeline settle
      while (replies_waiting != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && replies_waiting == 0) begin
         $display("address_interval_set_test passed");
      end else begin
         $display("address_interval_set_test failed");
      end
      $finish;
   end

endmodule

### files.f
sv/asi_pkg.sv
sv/asi_ram.sv
sv/asi_ctrl.sv
sv/asi_dpath.sv
sv/address_interval_set.sv
tb/address_interval_set_checker.sv
tb/address_interval_set_test.sv
